// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL; they expand to nothing for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property check, disabled while reset is asserted.
`define ASSERT_PROP(label, clk, rstn, prop) \
	label: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("%m: property check failed");
// Condition that must never be seen at a clock edge.
`define ASSERT_NEVER(label, clk, rstn, expr) \
	label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("%m: forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, expr)
`endif
`endif

// ===== src/rpcg_pkg.sv =====
// Shared types, widths and constants of the rotated pixel coordinate generator.
package rpcg_pkg;

	// Default parameter values
	localparam int MAX_SIDE_DEF  = 1024;
	localparam int FRAC_BITS_DEF = 16;

	// Field widths
	localparam int SIDE_W = 11;   // frame_width, frame_height
	localparam int DATA_W = 18;   // coordinates, steps, angles
	localparam int RAD_W  = 17;   // radius output
	localparam int SQ_W   = 36;   // x*x + y*y
	localparam int ROOT_W = SQ_W / 2;
	localparam int REM_W  = ROOT_W + 3;

	// Configuration port
	localparam int ADDR_W  = 5;
	localparam int PDATA_W = 32;

	// Register reset values
	localparam logic [SIDE_W-1:0]        FRAME_W_RST = SIDE_W'(64);
	localparam logic [SIDE_W-1:0]        FRAME_H_RST = SIDE_W'(64);
	localparam logic [DATA_W-1:0]        STEP_X_RST  = DATA_W'(2048);
	localparam logic [DATA_W-1:0]        STEP_Y_RST  = DATA_W'(2048);
	localparam logic signed [DATA_W-1:0] COS_RST     = DATA_W'(65536);
	localparam logic signed [DATA_W-1:0] SIN_RST     = DATA_W'(0);

	// Largest radius value
	localparam logic [RAD_W-1:0] RAD_MAX = '1;

	// Register indexes
	typedef enum logic [2:0] {
		REG_FRAME_WIDTH  = 3'd0,
		REG_FRAME_HEIGHT = 3'd1,
		REG_STEP_X       = 3'd2,
		REG_STEP_Y       = 3'd3,
		REG_COS_ANGLE    = 3'd4,
		REG_SIN_ANGLE    = 3'd5
	} reg_idx_t;

	// Unrotated point of one pixel
	typedef struct packed {
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] y;
		logic                     last;
	} pix_t;

	// Results carried beside the square root chain
	typedef struct packed {
		logic signed [DATA_W-1:0] rot_x;
		logic signed [DATA_W-1:0] rot_y;
		logic                     last;
	} side_t;

	// Square root working set handed from cell to cell
	typedef struct packed {
		logic [SQ_W-1:0]   rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sq_t;

	// Minus one at the given fraction width, clipped to the coordinate range
	function automatic logic signed [DATA_W-1:0] minus_one(input int frac);
		int v;
		v = (frac >= DATA_W - 1) ? -(1 << (DATA_W - 1)) : -(1 << frac);
		return DATA_W'(v);
	endfunction

endpackage

// ===== src/rpcg_scan.sv =====
// Raster scan counters and coordinate accumulators.
module rpcg_scan #(
	parameter int MAX_SIDE  = rpcg_pkg::MAX_SIDE_DEF,
	parameter int FRAC_BITS = rpcg_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic                              restart,
	input  logic [rpcg_pkg::SIDE_W-1:0]       frame_width,
	input  logic [rpcg_pkg::SIDE_W-1:0]       frame_height,
	input  logic [rpcg_pkg::DATA_W-1:0]       step_x,
	input  logic [rpcg_pkg::DATA_W-1:0]       step_y,
	output rpcg_pkg::pix_t                    pix
);

	localparam int CNT_W = $clog2(MAX_SIDE);
	localparam int LIM_W = $clog2(MAX_SIDE + 1);
	localparam int SW    = (LIM_W > rpcg_pkg::SIDE_W) ? LIM_W : rpcg_pkg::SIDE_W;
	localparam int DW    = rpcg_pkg::DATA_W;
	localparam logic signed [DW-1:0] MINUS_ONE = rpcg_pkg::minus_one(FRAC_BITS);
	localparam logic signed [DW+1:0] ACC_MAX   = (DW+2)'((1 << (DW - 1)) - 1);

	logic [CNT_W-1:0]     col_q, row_q;
	logic signed [DW-1:0] x_q, y_q;

	logic [CNT_W-1:0]     base_col, base_row;
	logic signed [DW-1:0] base_x, base_y;
	logic [SW-1:0]        eff_w, eff_h, col_nx, row_nx;
	logic                 end_row, end_frame;
	logic signed [DW+1:0] x_sum, y_sum;
	logic signed [DW-1:0] x_inc, y_inc;

	// Zero acts as one, oversize clips to the largest side
	function automatic logic [SW-1:0] eff_side(input logic [rpcg_pkg::SIDE_W-1:0] v);
		logic [SW-1:0] e;
		e = SW'(v);
		if (e == '0) begin
			return SW'(1);
		end
		if (e > SW'(MAX_SIDE)) begin
			return SW'(MAX_SIDE);
		end
		return e;
	endfunction

	// Current pixel, after an optional restart
	always_comb begin
		base_col  = restart ? '0 : col_q;
		base_row  = restart ? '0 : row_q;
		base_x    = restart ? MINUS_ONE : x_q;
		base_y    = restart ? MINUS_ONE : y_q;
		eff_w     = eff_side(frame_width);
		eff_h     = eff_side(frame_height);
		col_nx    = SW'(base_col) + SW'(1);
		row_nx    = SW'(base_row) + SW'(1);
		end_row   = col_nx >= eff_w;
		end_frame = end_row && (row_nx >= eff_h);
		pix.x     = base_x;
		pix.y     = base_y;
		pix.last  = end_frame;
	end

	// Saturating coordinate steps
	always_comb begin
		x_sum = {{2{base_x[DW-1]}}, base_x} + {2'b00, step_x};
		y_sum = {{2{base_y[DW-1]}}, base_y} + {2'b00, step_y};
		x_inc = (x_sum > ACC_MAX) ? ACC_MAX[DW-1:0] : x_sum[DW-1:0];
		y_inc = (y_sum > ACC_MAX) ? ACC_MAX[DW-1:0] : y_sum[DW-1:0];
	end

	// Advance the scan on every input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			x_q   <= MINUS_ONE;
			y_q   <= MINUS_ONE;
		end else if (accept) begin
			if (!end_row) begin
				col_q <= CNT_W'(col_nx);
				row_q <= base_row;
				x_q   <= x_inc;
				y_q   <= base_y;
			end else if (!end_frame) begin
				col_q <= '0;
				row_q <= CNT_W'(row_nx);
				x_q   <= MINUS_ONE;
				y_q   <= y_inc;
			end else begin
				col_q <= '0;
				row_q <= '0;
				x_q   <= MINUS_ONE;
				y_q   <= MINUS_ONE;
			end
		end
	end

endmodule

// ===== src/rpcg_rotate.sv =====
// Rotation products, rounding and the squared radius, two register stages.
module rpcg_rotate #(
	parameter int FRAC_BITS = rpcg_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              prev_valid,
	input  rpcg_pkg::pix_t                    pix,
	input  logic signed [rpcg_pkg::DATA_W-1:0] cos_angle,
	input  logic signed [rpcg_pkg::DATA_W-1:0] sin_angle,
	output logic                              next_valid,
	output rpcg_pkg::side_t                   side,
	output logic [rpcg_pkg::SQ_W-1:0]         rad
);

	localparam int DW    = rpcg_pkg::DATA_W;
	localparam int PW    = 2 * DW;
	localparam int SUM_W = PW + 2;
	localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [SUM_W-1:0] VMAX = SUM_W'((1 << (DW - 1)) - 1);
	localparam logic signed [SUM_W-1:0] VMIN = ~VMAX;

	logic signed [PW-1:0] xc_s2, ys_s2, xs_s2, yc_s2, xx_s2, yy_s2;
	logic                 last_s2, valid_s2;

	logic                 valid_s3;
	rpcg_pkg::side_t      side_s3;
	logic [rpcg_pkg::SQ_W-1:0] rad_s3;

	// Round half up at the fraction point, then clip to the output range
	function automatic logic signed [DW-1:0] round_sat(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] t;
		t = (v + HALF) >>> FRAC_BITS;
		if (t > VMAX) begin
			return VMAX[DW-1:0];
		end
		if (t < VMIN) begin
			return VMIN[DW-1:0];
		end
		return t[DW-1:0];
	endfunction

	// Stage 2: products
	always_ff @(posedge clk) begin
		if (en) begin
			xc_s2   <= $signed(pix.x) * $signed(cos_angle);
			ys_s2   <= $signed(pix.y) * $signed(sin_angle);
			xs_s2   <= $signed(pix.x) * $signed(sin_angle);
			yc_s2   <= $signed(pix.y) * $signed(cos_angle);
			xx_s2   <= $signed(pix.x) * $signed(pix.x);
			yy_s2   <= $signed(pix.y) * $signed(pix.y);
			last_s2 <= pix.last;
		end
	end

	// Stage 3: sums, rounding and the radicand
	always_ff @(posedge clk) begin
		if (en) begin
			side_s3.rot_x <= round_sat(SUM_W'(xc_s2) - SUM_W'(ys_s2));
			side_s3.rot_y <= round_sat(SUM_W'(xs_s2) + SUM_W'(yc_s2));
			side_s3.last  <= last_s2;
			rad_s3        <= $unsigned(xx_s2) + $unsigned(yy_s2);
		end
	end

	// Stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s2 <= prev_valid;
			valid_s3 <= valid_s2;
		end
	end

	assign next_valid = valid_s3;
	assign side       = side_s3;
	assign rad        = rad_s3;

endmodule

// ===== src/rpcg_sqrt_cell.sv =====
// One digit of the integer square root; cells chain into a row.
module rpcg_sqrt_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            prev_valid,
	input  rpcg_pkg::sq_t   prev_data,
	input  rpcg_pkg::side_t prev_side,
	output logic            next_valid,
	output rpcg_pkg::sq_t   next_data,
	output rpcg_pkg::side_t next_side
);

	localparam int RW = rpcg_pkg::REM_W;
	localparam int QW = rpcg_pkg::ROOT_W;
	localparam int SW = rpcg_pkg::SQ_W;

	logic            valid_q;
	rpcg_pkg::sq_t   data_q;
	rpcg_pkg::side_t side_q;

	logic [RW-1:0] rem_sh, trial;
	rpcg_pkg::sq_t calc;

	// Bring in the next two radicand bits and try a one digit
	always_comb begin
		rem_sh   = {prev_data.rem[RW-3:0], prev_data.rad[SW-1 -: 2]};
		trial    = RW'({prev_data.root, 2'b01});
		calc.rad = {prev_data.rad[SW-3:0], 2'b00};
		if (rem_sh >= trial) begin
			calc.rem  = rem_sh - trial;
			calc.root = {prev_data.root[QW-2:0], 1'b1};
		end else begin
			calc.rem  = rem_sh;
			calc.root = {prev_data.root[QW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= calc;
			side_q <= prev_side;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= prev_valid;
		end
	end

	assign next_valid = valid_q;
	assign next_data  = data_q;
	assign next_side  = side_q;

endmodule

// ===== src/rotated_pixel_coordinate_generator.sv =====
// Rotated pixel coordinate generator: config port, scan, rotation and radius chain.
// Pipeline: a result is shown after its input transfer passes the stage 1 pixel register,
//   two rotation stages, 18 square root cells and the output register.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset: registers return to 64x64, steps 2048, angle zero; scan goes to top-left.
`include "assert_macros.svh"
module rotated_pixel_coordinate_generator #(
	parameter int MAX_SIDE  = rpcg_pkg::MAX_SIDE_DEF,
	parameter int FRAC_BITS = rpcg_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [rpcg_pkg::ADDR_W-1:0]        paddr,
	input  logic [rpcg_pkg::PDATA_W-1:0]       pwdata,
	output logic [rpcg_pkg::PDATA_W-1:0]       prdata,
	output logic                               pready,
	// input channel
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               restart,
	// output channel
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [rpcg_pkg::DATA_W-1:0] rotated_x,
	output logic signed [rpcg_pkg::DATA_W-1:0] rotated_y,
	output logic [rpcg_pkg::RAD_W-1:0]         radius,
	output logic                               last_pixel
);

	localparam int DW = rpcg_pkg::DATA_W;
	localparam int NC = rpcg_pkg::ROOT_W;
	localparam logic signed [DW-1:0] MINUS_ONE = rpcg_pkg::minus_one(FRAC_BITS);

	// Configuration registers
	logic [rpcg_pkg::SIDE_W-1:0] frame_w_q, frame_h_q;
	logic [DW-1:0]               step_x_q, step_y_q;
	logic signed [DW-1:0]        cos_q, sin_q;

	logic               cfg_wr;
	rpcg_pkg::reg_idx_t cfg_idx;

	// Pipeline
	logic            adv, accept;
	rpcg_pkg::pix_t  pix_cur, pix_s1;
	logic            valid_s1;
	logic            rot_valid;
	rpcg_pkg::side_t rot_side;
	logic [rpcg_pkg::SQ_W-1:0] rot_rad;

	logic            chain_valid [NC+1];
	rpcg_pkg::sq_t   chain_data  [NC+1];
	rpcg_pkg::side_t chain_side  [NC+1];

	logic                        out_valid_q;
	logic signed [DW-1:0]        rx_q, ry_q;
	logic [rpcg_pkg::RAD_W-1:0]  rad_q;
	logic                        last_q;
	logic [rpcg_pkg::RAD_W-1:0]  rad_sat;

	// Configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = rpcg_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_w_q <= rpcg_pkg::FRAME_W_RST;
			frame_h_q <= rpcg_pkg::FRAME_H_RST;
			step_x_q  <= rpcg_pkg::STEP_X_RST;
			step_y_q  <= rpcg_pkg::STEP_Y_RST;
			cos_q     <= rpcg_pkg::COS_RST;
			sin_q     <= rpcg_pkg::SIN_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				rpcg_pkg::REG_FRAME_WIDTH:  frame_w_q <= pwdata[rpcg_pkg::SIDE_W-1:0];
				rpcg_pkg::REG_FRAME_HEIGHT: frame_h_q <= pwdata[rpcg_pkg::SIDE_W-1:0];
				rpcg_pkg::REG_STEP_X:       step_x_q  <= pwdata[DW-1:0];
				rpcg_pkg::REG_STEP_Y:       step_y_q  <= pwdata[DW-1:0];
				rpcg_pkg::REG_COS_ANGLE:    cos_q     <= pwdata[DW-1:0];
				rpcg_pkg::REG_SIN_ANGLE:    sin_q     <= pwdata[DW-1:0];
				default: ;
			endcase
		end
	end

	// Register read back, angles sign extended
	always_comb begin
		case (cfg_idx)
			rpcg_pkg::REG_FRAME_WIDTH:  prdata = rpcg_pkg::PDATA_W'(frame_w_q);
			rpcg_pkg::REG_FRAME_HEIGHT: prdata = rpcg_pkg::PDATA_W'(frame_h_q);
			rpcg_pkg::REG_STEP_X:       prdata = rpcg_pkg::PDATA_W'(step_x_q);
			rpcg_pkg::REG_STEP_Y:       prdata = rpcg_pkg::PDATA_W'(step_y_q);
			rpcg_pkg::REG_COS_ANGLE:    prdata = rpcg_pkg::PDATA_W'(cos_q);
			rpcg_pkg::REG_SIN_ANGLE:    prdata = rpcg_pkg::PDATA_W'(sin_q);
			default:                    prdata = '0;
		endcase
	end

	// Whole pipeline moves unless a result is held at the output
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;
	assign accept   = in_valid && adv;

	rpcg_scan #(
		.MAX_SIDE  (MAX_SIDE),
		.FRAC_BITS (FRAC_BITS)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.restart      (restart),
		.frame_width  (frame_w_q),
		.frame_height (frame_h_q),
		.step_x       (step_x_q),
		.step_y       (step_y_q),
		.pix          (pix_cur)
	);

	// Stage 1: pixel of the transfer
	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1 <= pix_cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	rpcg_rotate #(
		.FRAC_BITS (FRAC_BITS)
	) u_rotate (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.prev_valid (valid_s1),
		.pix        (pix_s1),
		.cos_angle  (cos_q),
		.sin_angle  (sin_q),
		.next_valid (rot_valid),
		.side       (rot_side),
		.rad        (rot_rad)
	);

	// Square root chain, one result bit per cell
	assign chain_valid[0]     = rot_valid;
	assign chain_data[0].rad  = rot_rad;
	assign chain_data[0].rem  = '0;
	assign chain_data[0].root = '0;
	assign chain_side[0]      = rot_side;

	for (genvar k = 0; k < NC; k++) begin : g_cell
		rpcg_sqrt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (adv),
			.prev_valid (chain_valid[k]),
			.prev_data  (chain_data[k]),
			.prev_side  (chain_side[k]),
			.next_valid (chain_valid[k+1]),
			.next_data  (chain_data[k+1]),
			.next_side  (chain_side[k+1])
		);
	end

	// Clip the root to the radius range
	assign rad_sat = chain_data[NC].root[NC-1] ? rpcg_pkg::RAD_MAX :
		chain_data[NC].root[rpcg_pkg::RAD_W-1:0];

	// Output register
	always_ff @(posedge clk) begin
		if (adv) begin
			rx_q   <= chain_side[NC].rot_x;
			ry_q   <= chain_side[NC].rot_y;
			rad_q  <= rad_sat;
			last_q <= chain_side[NC].last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= chain_valid[NC];
		end
	end

	assign out_valid  = out_valid_q;
	assign rotated_x  = rx_q;
	assign rotated_y  = ry_q;
	assign radius     = rad_q;
	assign last_pixel = last_q;

	// Checks
	`ASSERT_PROP(a_restart_corner, clk, arst_n, (in_valid && in_ready && restart) |=> (valid_s1 && pix_s1.x == MINUS_ONE && pix_s1.y == MINUS_ONE))
	`ASSERT_PROP(a_rotate_flow, clk, arst_n, (valid_s1 && adv) ##1 adv |=> rot_valid)
	`ASSERT_PROP(a_chain_to_out, clk, arst_n, (chain_valid[NC] && adv) |=> out_valid)

endmodule

// ===== tb/rotated_pixel_coordinate_generator_test.sv =====
// Self-checking testbench of the rotated pixel coordinate generator.
module rotated_pixel_coordinate_generator_test;

	localparam int     FRAC         = 16;
	localparam longint COORD_START  = -65536;    // minus one in Q.16
	localparam longint COORD_MAX    = 131071;
	localparam longint COORD_MIN    = -131072;
	localparam longint RAD_LIMIT    = 131071;
	localparam int     SIDE_LIMIT   = 1024;
	localparam int     LONG_HOLD    = 250;       // receiver hold-off, cycles
	localparam int     SETTLE_WAIT  = 30;        // extra wait after the last result, cycles
	localparam int     QUIET_LIMIT  = 3000;
	localparam int     REPORT_CAP   = 60;

	// Expected content of one result transfer
	typedef struct packed {
		logic signed [rpcg_pkg::DATA_W-1:0] rot_x;
		logic signed [rpcg_pkg::DATA_W-1:0] rot_y;
		logic [rpcg_pkg::RAD_W-1:0]         rad;
		logic                               last_px;
	} pixel_result_t;

	logic                               clk       = 1'b0;
	logic                               arst_n    = 1'b0;
	logic                               psel      = 1'b0;
	logic                               penable   = 1'b0;
	logic                               pwrite    = 1'b0;
	logic [rpcg_pkg::ADDR_W-1:0]        paddr     = '0;
	logic [rpcg_pkg::PDATA_W-1:0]       pwdata    = '0;
	logic [rpcg_pkg::PDATA_W-1:0]       prdata;
	logic                               pready;
	logic                               in_valid  = 1'b0;
	logic                               in_ready;
	logic                               restart   = 1'b0;
	logic                               out_valid;
	logic                               out_ready = 1'b0;
	logic signed [rpcg_pkg::DATA_W-1:0] rotated_x;
	logic signed [rpcg_pkg::DATA_W-1:0] rotated_y;
	logic [rpcg_pkg::RAD_W-1:0]         radius;
	logic                               last_pixel;

	// Scan model: register copies and scan position
	int unsigned cfg_width  = 32'(rpcg_pkg::FRAME_W_RST);
	int unsigned cfg_height = 32'(rpcg_pkg::FRAME_H_RST);
	longint      cfg_step_x = 64'(rpcg_pkg::STEP_X_RST);
	longint      cfg_step_y = 64'(rpcg_pkg::STEP_Y_RST);
	longint      cfg_cos    = 64'(rpcg_pkg::COS_RST);
	longint      cfg_sin    = 64'(rpcg_pkg::SIN_RST);
	int unsigned col_cnt    = 0;
	int unsigned row_cnt    = 0;
	longint      scan_x     = COORD_START;
	longint      scan_y     = COORD_START;

	logic          scan_requests[$];     // restart bits waiting to be sent
	pixel_result_t expected_pixels[$];   // predicted results in order

	int fail_count    = 0;
	int sent_count    = 0;
	int restart_count = 0;
	int checked_count = 0;
	int frame_ends    = 0;
	int phase_count   = 0;
	int phase_id      = 0;
	int held_phase    = -1;
	logic hold_req    = 1'b0;
	int send_gap      = 0;
	int send_burst    = 0;
	int stall_left    = 0;
	int recv_burst    = 0;

	rotated_pixel_coordinate_generator dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint clip_coord(input longint v);
		if (v > COORD_MAX) return COORD_MAX;
		if (v < COORD_MIN) return COORD_MIN;
		return v;
	endfunction

	// Round a Q.32 product sum to Q.16, ties upward, then clip
	function automatic longint round_clip(input longint v);
		return clip_coord((v + (longint'(1) << (FRAC - 1))) >>> FRAC);
	endfunction

	function automatic int unsigned eff_side(input int unsigned v);
		if (v == 0) return 1;
		if (v > SIDE_LIMIT) return SIDE_LIMIT;
		return v;
	endfunction

	function automatic void rewind_scan();
		col_cnt = 0;
		row_cnt = 0;
		scan_x  = COORD_START;
		scan_y  = COORD_START;
	endfunction

	// Result of the next pixel; advances the scan position
	function automatic pixel_result_t predict_pixel(input logic restart_req);
		int unsigned   cols, rows;
		longint        px, py, sq, root, trial;
		logic          row_end, frame_end;
		pixel_result_t res;
		int            b;
		cols = eff_side(cfg_width);
		rows = eff_side(cfg_height);
		if (restart_req)
			rewind_scan();
		px = scan_x;
		py = scan_y;
		res.rot_x = rpcg_pkg::DATA_W'(round_clip(px * cfg_cos - py * cfg_sin));
		res.rot_y = rpcg_pkg::DATA_W'(round_clip(px * cfg_sin + py * cfg_cos));
		// floor square root, one bit at a time from the top
		sq = px * px + py * py;
		root = 0;
		for (b = 18; b >= 0; b--) begin
			trial = root | (longint'(1) << b);
			if (trial * trial <= sq)
				root = trial;
		end
		res.rad = rpcg_pkg::RAD_W'((root > RAD_LIMIT) ? RAD_LIMIT : root);
		// a counter at or past its end closes the row or frame
		row_end   = (col_cnt + 1 >= cols);
		frame_end = row_end && (row_cnt + 1 >= rows);
		res.last_px = frame_end;
		if (!row_end) begin
			col_cnt = (col_cnt + 1) & 32'h3FF;
			scan_x  = clip_coord(scan_x + cfg_step_x);
		end else if (!frame_end) begin
			col_cnt = 0;
			scan_x  = COORD_START;
			row_cnt = (row_cnt + 1) & 32'h3FF;
			scan_y  = clip_coord(scan_y + cfg_step_y);
		end else begin
			rewind_scan();
		end
		return res;
	endfunction

	// Idle length: mostly none, some short, a few long
	function automatic int draw_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic note_mismatch(input string field, input longint want, input longint got);
		fail_count++;
		if (fail_count <= REPORT_CAP)
			$error("%s: expected %0d, got %0d", field, want, got);
	endtask

	// APB write: setup cycle, access cycle, model updated at the write edge
	task automatic write_reg(input rpcg_pkg::reg_idx_t idx,
			input logic [rpcg_pkg::PDATA_W-1:0] value);
		logic signed [rpcg_pkg::DATA_W-1:0] angle;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= rpcg_pkg::ADDR_W'(4 * idx);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		angle = value[rpcg_pkg::DATA_W-1:0];
		case (idx)
			rpcg_pkg::REG_FRAME_WIDTH:  cfg_width  = 32'(value[rpcg_pkg::SIDE_W-1:0]);
			rpcg_pkg::REG_FRAME_HEIGHT: cfg_height = 32'(value[rpcg_pkg::SIDE_W-1:0]);
			rpcg_pkg::REG_STEP_X:       cfg_step_x = 64'(value[rpcg_pkg::DATA_W-1:0]);
			rpcg_pkg::REG_STEP_Y:       cfg_step_y = 64'(value[rpcg_pkg::DATA_W-1:0]);
			rpcg_pkg::REG_COS_ANGLE:    cfg_cos    = 64'(angle);
			rpcg_pkg::REG_SIN_ANGLE:    cfg_sin    = 64'(angle);
			default: ;
		endcase
	endtask

	// All six registers; junk above each field width
	task automatic setup_frame(input int unsigned w, input int unsigned h,
			input int unsigned sx, input int unsigned sy, input int c, input int s);
		write_reg(rpcg_pkg::REG_FRAME_WIDTH, ($urandom << rpcg_pkg::SIDE_W) |
			rpcg_pkg::PDATA_W'(w[rpcg_pkg::SIDE_W-1:0]));
		write_reg(rpcg_pkg::REG_FRAME_HEIGHT, ($urandom << rpcg_pkg::SIDE_W) |
			rpcg_pkg::PDATA_W'(h[rpcg_pkg::SIDE_W-1:0]));
		write_reg(rpcg_pkg::REG_STEP_X, ($urandom << rpcg_pkg::DATA_W) |
			rpcg_pkg::PDATA_W'(sx[rpcg_pkg::DATA_W-1:0]));
		write_reg(rpcg_pkg::REG_STEP_Y, ($urandom << rpcg_pkg::DATA_W) |
			rpcg_pkg::PDATA_W'(sy[rpcg_pkg::DATA_W-1:0]));
		write_reg(rpcg_pkg::REG_COS_ANGLE, ($urandom << rpcg_pkg::DATA_W) |
			rpcg_pkg::PDATA_W'(c[rpcg_pkg::DATA_W-1:0]));
		write_reg(rpcg_pkg::REG_SIN_ANGLE, ($urandom << rpcg_pkg::DATA_W) |
			rpcg_pkg::PDATA_W'(s[rpcg_pkg::DATA_W-1:0]));
	endtask

	// Close a phase: optional long hold-off, then wait until the block is empty
	task automatic finish_phase(input logic long_hold);
		hold_req = long_hold;
		phase_id++;
		phase_count++;
		while (scan_requests.size() != 0 || in_valid || expected_pixels.size() != 0)
			@(negedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	// Input driver: one transfer per accepted item, random gaps and bursts
	always @(posedge clk or negedge arst_n) begin : pixel_driver
		if (!arst_n) begin
			in_valid <= 1'b0;
			restart  <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_pixels.push_back(predict_pixel(restart));
				sent_count++;
				if (restart)
					restart_count++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (scan_requests.size() != 0) begin
					in_valid <= 1'b1;
					restart  <= scan_requests.pop_front();
					if (send_burst > 0) begin
						send_burst--;
						send_gap = 0;
					end else if ($urandom_range(0, 40) == 0) begin
						send_burst = $urandom_range(20, 80);
						send_gap   = 0;
					end else begin
						send_gap = draw_idle();
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and out_ready pattern
	always @(posedge clk or negedge arst_n) begin : result_checker
		pixel_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				checked_count++;
				if (expected_pixels.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_CAP)
						$error("result transfer with no pixel pending");
				end else begin
					want = expected_pixels.pop_front();
					if (rotated_x !== want.rot_x)
						note_mismatch("rotated_x", 64'(want.rot_x), 64'(rotated_x));
					if (rotated_y !== want.rot_y)
						note_mismatch("rotated_y", 64'(want.rot_y), 64'(rotated_y));
					if (radius !== want.rad)
						note_mismatch("radius", 64'(want.rad), 64'(radius));
					if (last_pixel !== want.last_px)
						note_mismatch("last_pixel", 64'(want.last_px), 64'(last_pixel));
					if (want.last_px)
						frame_ends++;
				end
			end
			// long hold once per flagged phase, else random stalls and bursts
			if (hold_req && held_phase != phase_id) begin
				held_phase = phase_id;
				stall_left = LONG_HOLD;
			end else if (stall_left == 0) begin
				if (recv_burst > 0)
					recv_burst--;
				else if ($urandom_range(0, 40) == 0)
					recv_burst = $urandom_range(20, 80);
				else
					stall_left = draw_idle();
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: too long with no transfer on either channel
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("rotated_pixel_coordinate_generator test failed");
		$finish;
	end

	// Stimulus sequence
	initial begin : stimulus
		int unsigned w, h, sx, sy;
		int          c, s, k, i, n, pick;
		logic [11:0] first_pattern;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings, restart at start and mid-row
		first_pattern = 12'b1000_0100_0000;
		@(negedge clk);
		for (i = 11; i >= 0; i--)
			scan_requests.push_back(first_pattern[i]);
		finish_phase(1'b0);

		// zero sizes act as one: every pixel ends the frame; scan shrunk mid-row;
		// steps and angles at the 18-bit limits
		setup_frame(0, 0, 262143, 262143, -131072, 131071);
		@(negedge clk);
		scan_requests.push_back(1'b0);
		scan_requests.push_back(1'b0);
		scan_requests.push_back(1'b1);
		scan_requests.push_back(1'b0);
		finish_phase(1'b0);

		// oversized width, coordinate overflow into saturation
		setup_frame(2047, 2, 131072, 131072, 65536, 65536);
		@(negedge clk);
		for (i = 0; i < 8; i++)
			scan_requests.push_back(1'b0);
		finish_phase(1'b0);

		// random small frames, mostly continuous scans
		for (k = 0; k < 6; k++) begin
			pick = $urandom_range(0, 9);
			w = (pick == 0) ? 0 : (pick == 1) ? 2047 : $urandom_range(1, 12);
			h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
			sx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 262143)
				: 131072 / eff_side(w);
			sy = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 262143)
				: 131072 / eff_side(h);
			pick = $urandom_range(0, 9);
			if (pick < 5) begin
				case ($urandom_range(0, 5))
					0: begin c = 65536;  s = 0;      end
					1: begin c = 0;      s = 65536;  end
					2: begin c = -65536; s = 0;      end
					3: begin c = 0;      s = -65536; end
					4: begin c = 46341;  s = 46341;  end
					default: begin c = -46341; s = 46341; end
				endcase
			end else if (pick < 9) begin
				c = $urandom_range(0, 131072) - 65536;
				s = $urandom_range(0, 131072) - 65536;
			end else begin
				c = $urandom_range(0, 262143) - 131072;
				s = $urandom_range(0, 262143) - 131072;
			end
			setup_frame(w, h, sx, sy, c, s);
			@(negedge clk);
			n = $urandom_range(100, 140);
			for (i = 0; i < n; i++)
				scan_requests.push_back($urandom_range(0, 99) < 4);
			finish_phase(k == 2);
		end

		// one full row at the widest size, step 128, with a long hold-off
		setup_frame(1024, 1, 128, 2048, 56756, -32768);
		@(negedge clk);
		scan_requests.push_back(1'b1);
		for (i = 0; i < 1030; i++)
			scan_requests.push_back($urandom_range(0, 199) == 0);
		finish_phase(1'b1);

		$display("Ran %0d scan phases: %0d pixel requests (%0d with restart), %0d results",
			phase_count, sent_count, restart_count, checked_count);
		$display("checked, %0d frame ends seen, %0d failures.", frame_ends, fail_count);
		if (fail_count == 0)
			$display("rotated_pixel_coordinate_generator test passed");
		else
			$display("rotated_pixel_coordinate_generator test failed");
		$finish;
	end

endmodule
